>>> rtl/cascaded_moving_average_assert.svh
// assertion macros used by the moving average sequencer rtl
`ifndef CASCADED_MOVING_AVERAGE_ASSERT_SVH
`define CASCADED_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmavg assertion failed");

// next-cycle implication, checked out of reset
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmavg assertion failed");

`endif

>>> rtl/cmavg_pkg.sv
// shared constants and control types for the cascaded moving average
package cmavg_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed configuration register layout
  localparam int CFG_ADDR_BITS  = 1;
  localparam int CFG_DATA_BITS  = 7;
  localparam int STAGES_BITS    = 2;
  localparam int WINDOW_BITS    = 7;
  localparam int MIN_WINDOW     = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_FILTER_STAGES = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH = 1'd1;

  localparam logic [STAGES_BITS-1:0] STAGES_RESET = 2'd0;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd16;
  localparam logic [STAGES_BITS-1:0] STAGES_MAX   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } cmavg_state_t;

  typedef struct packed {
    logic load;    // capture input sample, restart at stage one
    logic read;    // read oldest ring entry of current stage
    logic update;  // update ring and sum, start divider
    logic next;    // take quotient as stage result
    logic emit;    // move result to output register
  } cmavg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_stage;
  } cmavg_status_t;

endpackage

>>> rtl/cmavg_div.sv
// serial signed divider, sum by window, truncated toward zero
module cmavg_div
  import cmavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW+1)-1:0] dividend,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]              divisor,
  output logic                                         done,
  output logic [SAMPLE_BITS-1:0]                       quotient
);

  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS = SAMPLE_BITS + WIN_BITS;
  localparam int CNT_BITS = $clog2(SAMPLE_BITS);

  logic [SUM_BITS-1:0]    mag;
  logic [WIN_BITS-1:0]    rem_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [WIN_BITS-1:0]    div_r;
  logic                   neg_r;
  logic                   busy_r;
  logic                   done_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic [WIN_BITS:0]      trial;
  logic                   fits;

  assign mag = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);

  // upper part of magnitude is always below the window, so only the low
  // sample-width bits need a step each
  assign trial = {rem_r, q_r[SAMPLE_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mag[SUM_BITS-1:SAMPLE_BITS];
      q_r   <= mag[SAMPLE_BITS-1:0];
      div_r <= divisor;
      neg_r <= dividend[SUM_BITS-1];
    end else if (busy_r) begin
      rem_r <= fits ? WIN_BITS'(trial - {1'b0, div_r}) : trial[WIN_BITS-1:0];
      q_r   <= {q_r[SAMPLE_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? SAMPLE_BITS'(-q_r) : q_r;

endmodule

>>> rtl/cmavg_datapath.sv
// ring memory, running sums, divider, config registers and output data register
module cmavg_datapath
  import cmavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  cmavg_cmd_t               cmd,
  output cmavg_status_t            status,
  output logic [SAMPLE_BITS-1:0]   out_average
);

  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + WIN_BITS;
  localparam int PTR_BITS  = $clog2(MAX_WINDOW);
  localparam int MEM_DEPTH = MAX_WINDOW + MAX_WINDOW / 2 + MAX_WINDOW / 4;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);
  localparam int NUM_STAGES = 3;

  logic [STAGES_BITS-1:0]     stages_r;
  logic [WINDOW_BITS-1:0]     window_r;
  logic [STAGES_BITS-1:0]     levels;
  logic [WIN_BITS-1:0]        win_clamped;
  logic [WIN_BITS-1:0]        stage_win;

  logic [SAMPLE_BITS-1:0]     mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0]     rd_data_r;
  logic [ADDR_BITS-1:0]       base;
  logic [ADDR_BITS-1:0]       addr;

  logic signed [SUM_BITS-1:0] sum_r  [NUM_STAGES];
  logic [PTR_BITS-1:0]        pos_r  [NUM_STAGES];
  logic [WIN_BITS-1:0]        fill_r [NUM_STAGES];
  logic [STAGES_BITS-1:0]     stage_r;
  logic [SAMPLE_BITS-1:0]     val_r;
  logic [SAMPLE_BITS-1:0]     out_data_r;

  logic [PTR_BITS-1:0]        pos_cur;
  logic [WIN_BITS-1:0]        fill_cur;
  logic [WIN_BITS-1:0]        pos_inc;
  logic                       old_valid;
  logic [SAMPLE_BITS-1:0]     old_val;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic [PTR_BITS-1:0]        pos_nxt;
  logic [WIN_BITS-1:0]        fill_nxt;
  logic                       div_done;
  logic [SAMPLE_BITS-1:0]     quotient;

  // config registers, any write restarts the filter from zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages_r <= STAGES_RESET;
      window_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FILTER_STAGES: stages_r <= cfg_wdata[STAGES_BITS-1:0];
        REG_WINDOW_LENGTH: window_r <= cfg_wdata[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign levels = (stages_r > STAGES_MAX) ? STAGES_MAX : stages_r;

  always_comb begin
    if (window_r < WINDOW_BITS'(MIN_WINDOW)) begin
      win_clamped = WIN_BITS'(MIN_WINDOW);
    end else if (32'(window_r) > MAX_WINDOW) begin
      win_clamped = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_clamped = WIN_BITS'(window_r);
    end
  end

  assign stage_win = win_clamped >> stage_r;

  always_comb begin
    case (stage_r)
      2'd1:    base = ADDR_BITS'(MAX_WINDOW);
      2'd2:    base = ADDR_BITS'(MAX_WINDOW + MAX_WINDOW / 2);
      default: base = '0;
    endcase
  end

  assign pos_cur  = pos_r[stage_r];
  assign fill_cur = fill_r[stage_r];
  assign addr     = base + ADDR_BITS'(pos_cur);

  // entries not yet written since the last clear read as zero
  assign old_valid = WIN_BITS'(pos_cur) < fill_cur;
  assign old_val   = old_valid ? rd_data_r : '0;
  assign sum_nxt   = sum_r[stage_r]
                   - {{WIN_BITS{old_val[SAMPLE_BITS-1]}}, old_val}
                   + {{WIN_BITS{val_r[SAMPLE_BITS-1]}}, val_r};
  assign pos_inc   = WIN_BITS'(pos_cur) + 1'b1;
  assign pos_nxt   = (pos_inc == stage_win) ? '0 : pos_inc[PTR_BITS-1:0];
  assign fill_nxt  = (fill_cur == stage_win) ? fill_cur : fill_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r <= mem[addr];
    end
    if (cmd.update) begin
      mem[addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        sum_r[i]  <= '0;
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
      end
      stage_r <= '0;
    end else begin
      if (cmd.load) begin
        stage_r <= '0;
      end else if (cmd.next && !status.last_stage) begin
        stage_r <= stage_r + 1'b1;
      end
      if (cmd.update) begin
        sum_r[stage_r]  <= sum_nxt;
        pos_r[stage_r]  <= pos_nxt;
        fill_r[stage_r] <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_sample;
    end else if (cmd.next) begin
      val_r <= quotient;
    end
    if (cmd.emit) begin
      out_data_r <= val_r;
    end
  end

  cmavg_div #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update),
    .dividend (sum_nxt),
    .divisor  (stage_win),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.div_done   = div_done;
  assign status.last_stage = (stage_r == levels);
  assign out_average       = out_data_r;

endmodule

>>> rtl/cmavg_ctrl.sv
// sequencing state machine and output handshake
`include "cascaded_moving_average_assert.svh"

module cmavg_ctrl
  import cmavg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  cmavg_status_t status,
  output cmavg_cmd_t    cmd
);

  cmavg_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.next  = 1'b1;
          state_nxt = status.last_stage ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  `CMA_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.emit, !out_valid_r || out_tready)
  `CMA_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_tvalid && in_tready, state_r == ST_READ)
  `CMA_ASSERT_NEXT(a_div_exit, clk, rst_n, cmd.next, state_r == ST_READ || state_r == ST_FINISH)
  `CMA_ASSERT_NOW(a_done_in_divide, clk, rst_n, status.div_done, state_r == ST_DIVIDE)

endmodule

>>> rtl/cascaded_moving_average.sv
// top level of the cascaded boxcar moving average filter
//
// in_* takes one signed q8.8 sample per beat, out_* gives one averaged
// sample per input beat, in order. one to three boxcar stages run in
// series with windows w, w/2 and w/4 (w = window_length, held in 4..MAX_WINDOW);
// filter_stages picks how many (value plus one, three when set to 3).
// each active stage does one ring read, one sum update and ring write,
// then the serial divider that forms sum / window (one quotient bit per
// cycle, then a done strobe). in_tready rises again in the same cycle
// as out_tvalid, once the result has moved to the output register.
// the output register lets the next sample be taken while a result waits;
// if the receiver stalls, the following result stays in the pipeline until
// the output register frees and in_tready stays low meanwhile.
// reset (and any config write) restarts the filter with all history zero;
// ring entries are tracked by per-stage fill counts, so no clearing pass.
// config writes are only legal while the block is idle.
module cascaded_moving_average
  import cmavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0]         cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]         cfg_wdata,
  // input sample channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [8*((SAMPLE_BITS+7)/8)-1:0] in_tdata,   // sample
  // averaged sample channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [8*((SAMPLE_BITS+7)/8)-1:0] out_tdata   // average
);

  localparam int TDATA_BITS = 8 * ((SAMPLE_BITS + 7) / 8);

  cmavg_cmd_t             cmd;
  cmavg_status_t          status;
  logic [SAMPLE_BITS-1:0] average;

  // sequencer: walks stages, owns the output valid flag
  cmavg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // rings, sums, divider and registers
  cmavg_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_average (average)
  );

  // zero padding up to whole bytes
  assign out_tdata = TDATA_BITS'(average);

endmodule
